// ===== rtl/kmu_pkg.sv =====
// Shared types and constants for the Kruskal maze union-find block.
// Holds the input mode codes, field widths and the controller/datapath
// command and status structs. No dependencies.
package kmu_pkg;

  localparam int DEF_GRID_SIZE = 16;
  localparam int MODE_W        = 2;
  localparam int COORD_W       = 4;
  localparam int COORD_CMP_W   = 8;

  localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic phase_b;
    logic step;
    logic set_root;
    logic comp_wr;
    logic size_rd_b;
    logic merge;
    logic wall_cap;
    logic clr_start;
    logic clr_step;
    logic emit;
  } kmu_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              fits;
    logic              on_grid;
    logic              found;
    logic              at_root;
    logic              same_root;
    logic              clr_last;
    logic              out_free;
  } kmu_stat_t;

endpackage

// ===== rtl/kmu_in_if.sv =====
// Input channel of the maze block: valid/ready handshake and one item.
// Depends on kmu_pkg for field widths.
interface kmu_in_if;
  logic                        valid;
  logic                        ready;
  logic [kmu_pkg::MODE_W-1:0]  mode;
  logic [kmu_pkg::COORD_W-1:0] col;
  logic [kmu_pkg::COORD_W-1:0] row;
  logic                        dir;

  modport source (output valid, mode, col, row, dir, input ready);
  modport sink   (input valid, mode, col, row, dir, output ready);
endinterface

// ===== rtl/kmu_out_if.sv =====
// Result channel of the maze block: valid/ready handshake and one item.
// No dependencies.
interface kmu_out_if;
  logic valid;
  logic ready;
  logic joined;
  logic complete;
  logic wall_right;
  logic wall_down;

  modport source (output valid, joined, complete, wall_right, wall_down, input ready);
  modport sink   (input valid, joined, complete, wall_right, wall_down, output ready);
endinterface

// ===== rtl/kmu_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/kmu_ctrl.sv =====
// Controller state machine of the maze block: sequences root walks, path
// compression, merge, wall reads and the clearing sweep. Depends on kmu_pkg.
module kmu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kmu_pkg::kmu_stat_t stat_i,
  output kmu_pkg::kmu_cmd_t  cmd_o
);
  import kmu_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_CLEAR      = 4'd2;
  localparam logic [3:0] S_FIND_ISSUE = 4'd3;
  localparam logic [3:0] S_FIND       = 4'd4;
  localparam logic [3:0] S_COMP_ISSUE = 4'd5;
  localparam logic [3:0] S_COMP       = 4'd6;
  localparam logic [3:0] S_SIZE_A     = 4'd7;
  localparam logic [3:0] S_SIZE_B     = 4'd8;
  localparam logic [3:0] S_MERGE      = 4'd9;
  localparam logic [3:0] S_WALL       = 4'd10;
  localparam logic [3:0] S_DONE       = 4'd11;

  logic [3:0] state_q, state_d;
  logic       phase_q, phase_d;
  logic       reply_q, reply_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= 1'b0;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      reply_q <= reply_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    reply_d       = reply_q;
    cmd_o         = '0;
    cmd_o.phase_b = phase_q;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.mode)
          MODE_EDGE: begin
            phase_d = 1'b0;
            state_d = stat_i.fits ? S_FIND_ISSUE : S_DONE;
          end
          MODE_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            reply_d         = 1'b1;
            state_d         = S_CLEAR;
          end
          MODE_READ: begin
            state_d = stat_i.on_grid ? S_WALL : S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          reply_d = 1'b0;
          state_d = reply_q ? S_DONE : S_IDLE;
        end
      end
      S_FIND_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = S_FIND;
      end
      S_FIND: begin
        if (stat_i.found) begin
          cmd_o.set_root = 1'b1;
          state_d        = S_COMP_ISSUE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_COMP_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = S_COMP;
      end
      S_COMP: begin
        if (stat_i.at_root) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            state_d = S_FIND_ISSUE;
          end else begin
            state_d = stat_i.same_root ? S_DONE : S_SIZE_A;
          end
        end else begin
          cmd_o.comp_wr = 1'b1;
          cmd_o.step    = 1'b1;
        end
      end
      S_SIZE_A: begin
        state_d = S_SIZE_B;
      end
      S_SIZE_B: begin
        cmd_o.size_rd_b = 1'b1;
        state_d         = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = S_DONE;
      end
      S_WALL: begin
        cmd_o.wall_cap = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/kmu_dp.sv =====
// Datapath of the maze block: item registers, parent/size/wall memories,
// walk and root registers, merge count and the result register.
// Depends on kmu_pkg and kmu_ram.
module kmu_dp #(
  parameter int GRID_SIZE = kmu_pkg::DEF_GRID_SIZE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [kmu_pkg::MODE_W-1:0]  mode_i,
  input  logic [kmu_pkg::COORD_W-1:0] col_i,
  input  logic [kmu_pkg::COORD_W-1:0] row_i,
  input  logic                        dir_i,
  input  kmu_pkg::kmu_cmd_t           cmd_i,
  output kmu_pkg::kmu_stat_t          stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        joined_o,
  output logic                        complete_o,
  output logic                        wall_right_o,
  output logic                        wall_down_o
);
  import kmu_pkg::*;

  localparam int CELLS  = GRID_SIZE * GRID_SIZE;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int SIZE_W = IDX_W + 1;

  logic [MODE_W-1:0]      mode_q;
  logic [COORD_W-1:0]     col_q, row_q;
  logic                   dir_q;
  logic [IDX_W-1:0]       cur_q, root_q, ra_q, rb_q, clr_q, cnt_q;
  logic [SIZE_W-1:0]      sa_q;
  logic                   res_joined_q, res_wr_q, res_wd_q;
  logic                   out_valid_q, out_joined_q, out_complete_q, out_wr_q, out_wd_q;

  logic [COORD_CMP_W-1:0] col_x, row_x, gs_x, one_x;
  logic                   fits, on_grid;
  logic [IDX_W-1:0]       c1, c2, start_addr;
  logic [IDX_W-1:0]       par_raddr, par_waddr, par_wdata, par_rdata;
  logic                   par_we;
  logic [IDX_W-1:0]       size_raddr, size_waddr, root_keep, root_hang;
  logic [SIZE_W-1:0]      size_wdata, size_rdata, size_sum;
  logic                   size_we;
  logic                   wr_we, wd_we, wall_wdata, wr_rdata, wd_rdata;

  assign col_x = COORD_CMP_W'(col_q);
  assign row_x = COORD_CMP_W'(row_q);
  assign gs_x  = COORD_CMP_W'(GRID_SIZE);
  assign one_x = COORD_CMP_W'(1);

  assign on_grid = (col_x < gs_x) && (row_x < gs_x);
  assign fits    = dir_q ? ((col_x < gs_x) && (row_x + one_x < gs_x))
                         : ((col_x + one_x < gs_x) && (row_x < gs_x));

  assign c1 = IDX_W'(int'(row_q) * GRID_SIZE + int'(col_q));
  assign c2 = dir_q ? IDX_W'(int'(c1) + GRID_SIZE) : IDX_W'(int'(c1) + 1);
  assign start_addr = cmd_i.phase_b ? c2 : c1;

  assign par_raddr = cmd_i.start ? start_addr : (cmd_i.step ? par_rdata : cur_q);

  assign root_keep = (sa_q < size_rdata) ? rb_q : ra_q;
  assign root_hang = (sa_q < size_rdata) ? ra_q : rb_q;
  assign size_sum  = sa_q + size_rdata;

  always_comb begin
    par_we    = 1'b0;
    par_waddr = cur_q;
    par_wdata = root_q;
    if (cmd_i.clr_step) begin
      par_we    = 1'b1;
      par_waddr = clr_q;
      par_wdata = clr_q;
    end else if (cmd_i.comp_wr) begin
      par_we = 1'b1;
    end else if (cmd_i.merge) begin
      par_we    = 1'b1;
      par_waddr = root_hang;
      par_wdata = root_keep;
    end
  end

  assign size_raddr = cmd_i.size_rd_b ? rb_q : ra_q;
  assign size_we    = cmd_i.clr_step || cmd_i.merge;
  assign size_waddr = cmd_i.clr_step ? clr_q : root_keep;
  assign size_wdata = cmd_i.clr_step ? SIZE_W'(1) : size_sum;

  assign wr_we      = cmd_i.clr_step || (cmd_i.merge && !dir_q);
  assign wd_we      = cmd_i.clr_step || (cmd_i.merge && dir_q);
  assign wall_wdata = cmd_i.clr_step;

  kmu_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_parent (
    .clk_i, .we_i(par_we), .waddr_i(par_waddr), .wdata_i(par_wdata),
    .raddr_i(par_raddr), .rdata_o(par_rdata)
  );

  kmu_ram #(.WIDTH(SIZE_W), .DEPTH(CELLS)) u_size (
    .clk_i, .we_i(size_we), .waddr_i(size_waddr), .wdata_i(size_wdata),
    .raddr_i(size_raddr), .rdata_o(size_rdata)
  );

  kmu_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_right (
    .clk_i, .we_i(wr_we), .waddr_i(cmd_i.clr_step ? clr_q : c1), .wdata_i(wall_wdata),
    .raddr_i(c1), .rdata_o(wr_rdata)
  );

  kmu_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_down (
    .clk_i, .we_i(wd_we), .waddr_i(cmd_i.clr_step ? clr_q : c1), .wdata_i(wall_wdata),
    .raddr_i(c1), .rdata_o(wd_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q       <= mode_i;
      col_q        <= col_i;
      row_q        <= row_i;
      dir_q        <= dir_i;
      res_joined_q <= 1'b0;
      res_wr_q     <= 1'b0;
      res_wd_q     <= 1'b0;
    end
    if (cmd_i.start) begin
      cur_q <= start_addr;
    end else if (cmd_i.step) begin
      cur_q <= par_rdata;
    end
    if (cmd_i.set_root) begin
      root_q <= cur_q;
      if (cmd_i.phase_b) begin
        rb_q <= cur_q;
      end else begin
        ra_q <= cur_q;
      end
    end
    if (cmd_i.size_rd_b) begin
      sa_q <= size_rdata;
    end
    if (cmd_i.merge) begin
      res_joined_q <= 1'b1;
    end
    if (cmd_i.wall_cap) begin
      res_wr_q <= wr_rdata;
      res_wd_q <= wd_rdata;
    end
    if (cmd_i.emit) begin
      out_joined_q   <= res_joined_q;
      out_complete_q <= (cnt_q == IDX_W'(CELLS - 1));
      out_wr_q       <= res_wr_q;
      out_wd_q       <= res_wd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_start) begin
        clr_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + IDX_W'(1);
      end else if (cmd_i.merge) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o           = '0;
    stat_o.mode      = mode_q;
    stat_o.fits      = fits;
    stat_o.on_grid   = on_grid;
    stat_o.found     = (par_rdata == cur_q);
    stat_o.at_root   = (cur_q == root_q);
    stat_o.same_root = (ra_q == rb_q);
    stat_o.clr_last  = (clr_q == IDX_W'(CELLS - 1));
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign joined_o     = out_joined_q;
  assign complete_o   = out_complete_q;
  assign wall_right_o = out_wr_q;
  assign wall_down_o  = out_wd_q;

  a_merge_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.merge |-> ra_q != rb_q)
    else $error("merge of two cells that share a root");

  a_comp_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.comp_wr |-> cur_q != root_q)
    else $error("compression write on the root itself");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_merge_after_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.merge |-> $past(cmd_i.size_rd_b))
    else $error("merge without both set sizes read");

endmodule

// ===== rtl/kruskal_maze_union_find.sv =====
// Kruskal maze union-find, top level. An edge offer walks both cells to their roots
// through the single read port of the parent memory; a root walk is at most log2 of
// the cell count deep. One item in flight; the next is taken once its result sits
// in the output register. After reset a clearing pass over all GRID_SIZE*GRID_SIZE
// cells runs before the first item is accepted.
module kruskal_maze_union_find #(
  parameter int GRID_SIZE = kmu_pkg::DEF_GRID_SIZE
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  kmu_in_if.sink           in_i,
  kmu_out_if.source        out_o
);
  import kmu_pkg::*;

  kmu_cmd_t  cmd;
  kmu_stat_t stat;
  logic      in_ready;

  kmu_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kmu_dp #(.GRID_SIZE(GRID_SIZE)) u_dp (
    .clk_i,
    .rst_ni,
    .mode_i       (in_i.mode),
    .col_i        (in_i.col),
    .row_i        (in_i.row),
    .dir_i        (in_i.dir),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .joined_o     (out_o.joined),
    .complete_o   (out_o.complete),
    .wall_right_o (out_o.wall_right),
    .wall_down_o  (out_o.wall_down)
  );

  assign in_i.ready = in_ready;

endmodule
